// File: src/dle_pkg.sv
// Package for the DLE-framed packet deframer: parse phase type, ring size,
// register map and reset values. No dependencies.
package dle_pkg;

  // Ring of byte slots that the consumer stores received bytes in
  localparam int unsigned RING_SLOTS = 256;
  localparam int unsigned SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  // Offset from the frame start escape to the first payload byte
  localparam int unsigned PAYLOAD_OFFSET = 3;

  // Register reset values
  localparam logic [7:0] ESCAPE_RESET     = 8'h10;
  localparam logic [7:0] TERMINATOR_RESET = 8'h03;

  // Register map: index taken from paddr[2]
  localparam logic REG_ESCAPE     = 1'b0;
  localparam logic REG_TERMINATOR = 1'b1;

  typedef enum logic [2:0] {
    PH_DATA  = 3'd0,
    PH_START = 3'd1,
    PH_ID    = 3'd2,
    PH_SIZE  = 3'd3,
    PH_END   = 3'd4
  } phase_e;

endpackage

// File: src/dle_framed_packet_deframer.sv
// DLE-framed packet deframer top level: input register, phase tracking and
// result register, plus the APB register port. Depends on dle_pkg.

// One received byte per input beat, one result beat per byte, in order. A byte
// is held in the input register on acceptance and then moves to the result
// register; with the output side not stalling, a new byte can be taken every
// cycle; the input stalls only while the input and result registers are held.
// The block tracks the frame phase (data, start, id, size, end), de-stuffs a
// doubled escape (its ring slot is reused by the next byte), flags the end
// marker (escape then terminator), and reports the captured id, size, payload
// start and end slot. Slots wrap around a ring of RING_SLOTS entries. Escape
// and terminator values are programmed through APB at byte addresses 0 and 4;
// write them only while no byte is in flight.
module dle_framed_packet_deframer
  import dle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // APB register port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  // Byte input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] slot_index_o,
  output logic [7:0] stored_byte_o,
  output logic       was_destuffed_o,
  output logic [2:0] phase_o,
  output logic       frame_done_o,
  output logic [7:0] packet_id_o,
  output logic [7:0] packet_size_o,
  output logic [7:0] payload_start_o,
  output logic [7:0] frame_end_slot_o
);

  // Configuration registers
  logic [7:0] escape_q, terminator_q;
  logic       cfg_wr;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  phase_e              phase_q, phase_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [7:0]          prev_q;
  logic                have_prev_q;
  logic [7:0]          id_q, id_d;
  logic [7:0]          size_q, size_d;
  logic [7:0]          start_q, start_d;
  logic [7:0]          end_q, end_d;
  logic                destuffed_d, done_d;

  // Result register
  logic                out_valid_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [7:0]          res_byte_q;
  logic                res_destuffed_q;
  phase_e              res_phase_q;
  logic                res_done_q;
  logic [7:0]          res_id_q, res_size_q, res_start_q, res_end_q;

  // Handshake
  logic in_take, stage_adv, out_free;
  logic after_esc;
  logic [SLOT_W:0] start_sum;

  // APB access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_ESCAPE:     prdata = {24'd0, escape_q};
      REG_TERMINATOR: prdata = {24'd0, terminator_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q     <= ESCAPE_RESET;
      terminator_q <= TERMINATOR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ESCAPE) begin
        escape_q <= pwdata[7:0];
      end else begin
        terminator_q <= pwdata[7:0];
      end
    end
  end

  // Flow control: the result register frees up when empty or taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign stage_adv  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Hold one byte in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (stage_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Next phase and captured fields for the registered byte
  assign after_esc = have_prev_q && (prev_q == escape_q);
  assign start_sum = {1'b0, slot_q} + (SLOT_W+1)'(PAYLOAD_OFFSET);

  always_comb begin
    phase_d     = phase_q;
    id_d        = id_q;
    size_d      = size_q;
    start_d     = start_q;
    end_d       = end_q;
    destuffed_d = 1'b0;
    done_d      = 1'b0;

    // Capture the header bytes
    if (phase_q == PH_START) begin
      id_d    = in_byte_q;
      phase_d = PH_ID;
    end else if (phase_q == PH_ID) begin
      size_d  = in_byte_q;
      phase_d = PH_SIZE;
    end

    if (in_byte_q == escape_q) begin
      if (after_esc) begin
        destuffed_d = 1'b1;
        phase_d     = PH_DATA;
      end else if (phase_d == PH_END) begin
        // Open a new frame
        if (start_sum >= (SLOT_W+1)'(RING_SLOTS)) begin
          start_d = 8'(start_sum - (SLOT_W+1)'(RING_SLOTS));
        end else begin
          start_d = 8'(start_sum);
        end
        phase_d = PH_START;
      end
    end else if (in_byte_q == terminator_q) begin
      if (after_esc) begin
        end_d   = 8'(slot_q);
        phase_d = PH_END;
        done_d  = 1'b1;
      end else if (phase_d == PH_ID || phase_d == PH_SIZE) begin
        phase_d = PH_DATA;
      end
    end else if (phase_d != PH_ID && phase_d != PH_SIZE) begin
      phase_d = PH_DATA;
    end
  end

  // Advance the ring slot unless the byte was de-stuffed
  always_comb begin
    slot_d = slot_q;
    if (!destuffed_d) begin
      if (slot_q == SLOT_W'(RING_SLOTS - 1)) begin
        slot_d = '0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  // Update parser state on each advanced byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      slot_q      <= '0;
      prev_q      <= 8'd0;
      have_prev_q <= 1'b0;
      id_q        <= 8'd0;
      size_q      <= 8'd0;
      start_q     <= 8'd0;
      end_q       <= 8'd0;
    end else if (stage_adv) begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      prev_q      <= in_byte_q;
      have_prev_q <= 1'b1;
      id_q        <= id_d;
      size_q      <= size_d;
      start_q     <= start_d;
      end_q       <= end_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      res_slot_q      <= slot_q;
      res_byte_q      <= in_byte_q;
      res_destuffed_q <= destuffed_d;
      res_phase_q     <= phase_d;
      res_done_q      <= done_d;
      res_id_q        <= id_d;
      res_size_q      <= size_d;
      res_start_q     <= start_d;
      res_end_q       <= end_d;
    end
  end

  // Drive the result beat
  assign out_valid_o      = out_valid_q;
  assign slot_index_o     = 8'(res_slot_q);
  assign stored_byte_o    = res_byte_q;
  assign was_destuffed_o  = res_destuffed_q;
  assign phase_o          = res_phase_q;
  assign frame_done_o     = res_done_q;
  assign packet_id_o      = res_id_q;
  assign packet_size_o    = res_size_q;
  assign payload_start_o  = res_start_q;
  assign frame_end_slot_o = res_end_q;

endmodule
